[hdl/ax25_hdlc_nrzi_framer_defines.svh]
// Assertion macros for the AX.25 HDLC NRZI framer.
// No dependencies; included by the modules that carry assertions.
`ifndef AX25_HDLC_NRZI_FRAMER_DEFINES_SVH
`define AX25_HDLC_NRZI_FRAMER_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define AX25F_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle.
`define AX25F_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`else
`define AX25F_ASSERT(lbl, clk, rst, prop, msg)
`define AX25F_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[hdl/ax25f_pkg.sv]
// Shared constants, types and the CRC helper for the AX.25 HDLC NRZI framer.
// No dependencies.
package ax25f_pkg;

   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_FLAG  = 2'd1;
   localparam logic [1:0] MODE_DATA  = 2'd2;
   localparam logic [1:0] MODE_FCS   = 2'd3;

   localparam logic [15:0] CRC_POLY  = 16'h8408;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [7:0]  HDLC_FLAG = 8'h7E;

   // consecutive ones already counted when the next one forces a stuffed zero
   localparam logic [2:0] STUFF_LIMIT = 3'd4;

   localparam int          CNT_W     = 5;
   localparam logic [CNT_W-1:0] BYTE_BITS = 5'd8;
   localparam logic [CNT_W-1:0] WORD_BITS = 5'd16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] payload;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Fold one byte into the reflected CRC-16, least significant bit first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int j = 0; j < 8; j++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[hdl/ax25f_front.sv]
// Front end of the framer: accepts items, keeps the CRC and builds queue entries.
// Depends on ax25f_pkg.
module ax25f_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [1:0]                req_mode,
   input  logic [7:0]                req_data_byte,
   input  ax25f_pkg::queue_status_type q_status,
   output logic                      q_push,
   output ax25f_pkg::queue_entry_type q_entry
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;

   assign q_push = req_valid && !q_status.full;

   always_comb begin
      crc_in        = crc_ff;
      q_entry.mode  = req_mode;
      q_entry.payload = 16'h0000;
      unique case (req_mode)
         ax25f_pkg::MODE_START: begin
            crc_in = ax25f_pkg::CRC_INIT;
         end
         ax25f_pkg::MODE_FLAG: begin
            q_entry.payload = {8'h00, ax25f_pkg::HDLC_FLAG};
         end
         ax25f_pkg::MODE_DATA: begin
            crc_in          = ax25f_pkg::crc_byte(crc_ff, req_data_byte);
            q_entry.payload = {8'h00, req_data_byte};
         end
         default: begin
            q_entry.payload = crc_ff ^ ax25f_pkg::CRC_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= ax25f_pkg::CRC_INIT;
      end else if (q_push) begin
         crc_ff <= crc_in;
      end
   end

endmodule

[hdl/ax25f_queue.sv]
// Short FIFO of classified items between front and back end.
// Depends on ax25f_pkg.
module ax25f_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ax25f_pkg::queue_entry_type push_entry,
   input  logic                       pop,
   output ax25f_pkg::queue_entry_type head,
   output ax25f_pkg::queue_status_type status
);

   localparam logic [ax25f_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      ax25f_pkg::QUEUE_PTR_W'(ax25f_pkg::QUEUE_DEPTH - 1);
   localparam logic [ax25f_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
      ax25f_pkg::QUEUE_CNT_W'(ax25f_pkg::QUEUE_DEPTH);

   ax25f_pkg::queue_entry_type slot_ff [ax25f_pkg::QUEUE_DEPTH];
   logic [ax25f_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ax25f_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ax25f_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[hdl/ax25f_back.sv]
// Back end of the framer: serialises queue entries, stuffs zeros, NRZI-codes each bit.
// Depends on ax25f_pkg and ax25_hdlc_nrzi_framer_defines.svh.
`include "ax25_hdlc_nrzi_framer_defines.svh"
module ax25f_back (
   input  logic                        clock,
   input  logic                        reset,
   input  ax25f_pkg::queue_entry_type  head,
   input  ax25f_pkg::queue_status_type q_status,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_raw_bit,
   output logic                        rsp_line_tone,
   output logic                        rsp_last_bit
);

   logic                        busy_ff, busy_in;
   logic                        stuff_en_ff, stuff_en_in;
   logic                        stuff_pend_ff, stuff_pend_in;
   logic [2:0]                  ones_ff, ones_in;
   logic                        tone_ff, tone_in;
   logic [15:0]                 shift_ff, shift_in;
   logic [ax25f_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        raw_ff, raw_in;
   logic                        line_ff, line_in;
   logic                        last_ff, last_in;

   logic advance, emit, bit_val, stuff_next, last, can_load;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign emit    = advance && busy_ff;

   always_comb begin
      if (stuff_pend_ff) begin
         bit_val    = 1'b0;
         stuff_next = 1'b0;
         last       = (cnt_ff == '0);
      end else begin
         bit_val    = shift_ff[0];
         stuff_next = stuff_en_ff && shift_ff[0] && (ones_ff == ax25f_pkg::STUFF_LIMIT);
         last       = (cnt_ff == ax25f_pkg::CNT_W'(1)) && !stuff_next;
      end
   end

   assign can_load = !busy_ff || (emit && last);
   assign q_pop    = can_load && !q_status.empty;

   always_comb begin
      busy_in       = busy_ff;
      stuff_en_in   = stuff_en_ff;
      stuff_pend_in = stuff_pend_ff;
      ones_in       = ones_ff;
      tone_in       = tone_ff;
      shift_in      = shift_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      raw_in        = raw_ff;
      line_in       = line_ff;
      last_in       = last_ff;

      if (emit) begin
         tone_in       = bit_val ? tone_ff : ~tone_ff;
         stuff_pend_in = stuff_next;
         busy_in       = !last;
         if (stuff_pend_ff || !stuff_en_ff || !bit_val || stuff_next) begin
            ones_in = 3'd0;
         end else begin
            ones_in = ones_ff + 3'd1;
         end
         if (!stuff_pend_ff) begin
            shift_in = shift_ff >> 1;
            cnt_in   = cnt_ff - 1'b1;
         end
      end

      if (advance) begin
         rsp_valid_in = emit;
         if (emit) begin
            raw_in  = bit_val;
            line_in = bit_val ? tone_ff : ~tone_ff;
            last_in = last;
         end
      end

      if (q_pop) begin
         shift_in      = head.payload;
         stuff_pend_in = 1'b0;
         unique case (head.mode)
            ax25f_pkg::MODE_START: begin
               busy_in = 1'b0;
               tone_in = 1'b1;
               ones_in = 3'd0;
            end
            ax25f_pkg::MODE_FLAG: begin
               busy_in     = 1'b1;
               stuff_en_in = 1'b0;
               cnt_in      = ax25f_pkg::BYTE_BITS;
            end
            ax25f_pkg::MODE_DATA: begin
               busy_in     = 1'b1;
               stuff_en_in = 1'b1;
               cnt_in      = ax25f_pkg::BYTE_BITS;
            end
            default: begin
               busy_in     = 1'b1;
               stuff_en_in = 1'b1;
               cnt_in      = ax25f_pkg::WORD_BITS;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         stuff_en_ff   <= 1'b0;
         stuff_pend_ff <= 1'b0;
         ones_ff       <= 3'd0;
         tone_ff       <= 1'b1;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         stuff_en_ff   <= stuff_en_in;
         stuff_pend_ff <= stuff_pend_in;
         ones_ff       <= ones_in;
         tone_ff       <= tone_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      raw_ff   <= raw_in;
      line_ff  <= line_in;
      last_ff  <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_raw_bit   = raw_ff;
   assign rsp_line_tone = line_ff;
   assign rsp_last_bit  = last_ff;

   `AX25F_ASSERT_IMPL(a_pend_busy, clock, reset, stuff_pend_ff, busy_ff, "stuff pending while idle")
   `AX25F_ASSERT_IMPL(a_pend_ones, clock, reset, stuff_pend_ff, ones_ff == 3'd0, "ones run not cleared")
   `AX25F_ASSERT_IMPL(a_flag_nostuff, clock, reset, busy_ff && !stuff_en_ff, !stuff_pend_ff, "flag bit stuffed")
   `AX25F_ASSERT_IMPL(a_cnt_live, clock, reset, busy_ff && !stuff_pend_ff, cnt_ff != '0, "busy with no bits left")

endmodule

[hdl/ax25_hdlc_nrzi_framer.sv]
// Top level of the AX.25 HDLC transmit framer with NRZI line coding.
// Depends on ax25f_pkg, ax25f_front, ax25f_queue and ax25f_back.
//
// Each request transaction carries a mode and a byte. Start clears the CRC, the ones
// count and the tone (back to mark) and sends nothing; flag sends 0x7E unstuffed;
// data folds the byte into the CRC-16 (reflected, 0x8408, preset all ones) and sends
// it LSB first with a zero inserted after five ones; FCS sends the complemented CRC,
// low byte first, stuffed the same way. Every line bit, stuffed zeros included, is
// one response transaction carrying the raw bit, the NRZI tone after it (toggle on
// zero) and a flag marking the last bit of its item. Rate: one line bit per clock
// while the response is not stalled, set by the serialiser in the back end; a run
// of ones carried in from the previous item can force an early stuffed zero, and a
// start holds the serialiser without sending a bit. A four-entry queue parts the
// front end, which takes one request per clock while there is room, from the
// serialiser, so requests are taken while earlier bits still drain and a stalled
// response holds only the serialiser. A request passes through the queue slot, the
// serialiser shift register and the response register before its first bit shows.
module ax25_hdlc_nrzi_framer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_raw_bit,
   output logic       rsp_line_tone,
   output logic       rsp_last_bit
);

   ax25f_pkg::queue_entry_type  q_entry;
   ax25f_pkg::queue_entry_type  q_head;
   ax25f_pkg::queue_status_type q_status;
   logic                        q_push;
   logic                        q_pop;

   // hold requests only when the queue has no room
   assign req_stall = q_status.full;

   ax25f_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   ax25f_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   // advance one line bit per clock whenever the response register is free
   ax25f_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (q_head),
      .q_status      (q_status),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_raw_bit   (rsp_raw_bit),
      .rsp_line_tone (rsp_line_tone),
      .rsp_last_bit  (rsp_last_bit)
   );

endmodule

[dv/tb_ax25_hdlc_nrzi_framer.sv]
`timescale 1ns / 100ps
// Self-checking testbench for ax25_hdlc_nrzi_framer: a directed table, then random frames.
// Depends on ax25f_pkg and on the framer RTL; it predicts every line bit on its own.

module tb_ax25_hdlc_nrzi_framer;

   localparam int DIRECTED_ROWS = 24;
   localparam int RANDOM_ITEMS  = 205;
   localparam int DRAIN_CYCLES  = 40;
   localparam int WATCHDOG_NS   = 20_000_000;
   localparam int MAX_LINE_BITS = 20;
   localparam logic [2:0] RUN_LIMIT = 3'd5;

   // One line bit as it leaves the serialiser.
   typedef struct packed {
      logic raw;
      logic tone;
      logic last;
   } line_bit_type;

   // One row of stimulus. Where typed is set, the bit pattern is written out by hand:
   // bit i of raw and tone belongs to the i-th line bit that the item sends.
   typedef struct {
      logic [1:0]               mode;
      logic [7:0]               data_val;
      logic                     typed;
      int                       n_bits;
      logic [MAX_LINE_BITS-1:0] raw;
      logic [MAX_LINE_BITS-1:0] tone;
   } stim_row_type;

   logic clock         = 1'b0;
   logic reset         = 1'b1;
   logic req_valid     = 1'b0;
   logic [1:0] req_mode      = ax25f_pkg::MODE_START;
   logic [7:0] req_data_byte = 8'h00;
   logic rsp_stall     = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_raw_bit;
   logic rsp_line_tone;
   logic rsp_last_bit;

   // Predictor state: running FCS, count of consecutive ones, NRZI tone.
   logic [15:0] fcs_crc;
   logic [2:0]  ones_seen;
   logic        nrzi_tone;

   line_bit_type item_bits[$];   // line bits of the transaction just accepted
   line_bit_type bits_due[$];    // line bits still to come out, oldest first
   int           mismatches = 0;
   int           random_sent = 0;
   bit           quiet = 1'b0;   // set for a frame: neither side idles

   ax25_hdlc_nrzi_framer i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_raw_bit   (rsp_raw_bit),
      .rsp_line_tone (rsp_line_tone),
      .rsp_last_bit  (rsp_last_bit)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Hold reset at the start, then release it for good.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Emit one line bit: a zero toggles the tone, a one holds it.
   function automatic void put_line_bit(input logic b);
      if (!b) nrzi_tone = ~nrzi_tone;
      item_bits.push_back('{raw: b, tone: nrzi_tone, last: 1'b0});
   endfunction

   // Send a byte LSB first, inserting a zero after every run of five ones.
   function automatic void send_stuffed_byte(input logic [7:0] v);
      for (int k = 0; k < 8; k++) begin
         put_line_bit(v[k]);
         if (v[k]) begin
            ones_seen = ones_seen + 3'd1;
            if (ones_seen >= RUN_LIMIT) begin
               put_line_bit(1'b0);
               ones_seen = 3'd0;
            end
         end else begin
            ones_seen = 3'd0;
         end
      end
   endfunction

   // Shift a byte through the reflected CRC-16 one bit at a time.
   function automatic void fold_fcs(input logic [7:0] v);
      logic fb;
      for (int k = 0; k < 8; k++) begin
         fb      = fcs_crc[0] ^ v[k];
         fcs_crc = fcs_crc >> 1;
         if (fb) fcs_crc = fcs_crc ^ ax25f_pkg::CRC_POLY;
      end
   endfunction

   // Work out the line bits of one accepted transaction and advance the state.
   function automatic void frame_line_bits(input logic [1:0] mode, input logic [7:0] v);
      logic [15:0] fcs;
      item_bits.delete();
      case (mode)
         ax25f_pkg::MODE_START: begin
            fcs_crc   = ax25f_pkg::CRC_INIT;
            ones_seen = 3'd0;
            nrzi_tone = 1'b1;
         end
         ax25f_pkg::MODE_FLAG: begin
            // flags go out unstuffed; the closing zero clears the run
            for (int k = 0; k < 8; k++) put_line_bit(ax25f_pkg::HDLC_FLAG[k]);
            ones_seen = 3'd0;
         end
         ax25f_pkg::MODE_DATA: begin
            fold_fcs(v);
            send_stuffed_byte(v);
         end
         default: begin
            // FCS leaves the CRC alone, so a repeat sends the same two bytes
            fcs = ~fcs_crc;
            send_stuffed_byte(fcs[7:0]);
            send_stuffed_byte(fcs[15:8]);
         end
      endcase
      if (item_bits.size() > 0) item_bits[item_bits.size()-1].last = 1'b1;
   endfunction

   // Offer one request transaction, wait for it to be taken, then queue its line bits.
   task automatic send_item(input stim_row_type r);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= r.mode;
      req_data_byte <= r.data_val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      frame_line_bits(r.mode, r.data_val);
      if (r.typed) begin
         // hand-written pattern replaces the prediction; the state still advances
         item_bits.delete();
         for (int i = 0; i < r.n_bits; i++)
            item_bits.push_back('{raw: r.raw[i], tone: r.tone[i], last: (i == r.n_bits - 1)});
      end
      foreach (item_bits[i]) bits_due.push_back(item_bits[i]);
   endtask

   task automatic send_plain(input logic [1:0] mode, input logic [7:0] v);
      stim_row_type r;
      r = '{mode, v, 1'b0, 0, '0, '0};
      send_item(r);
      random_sent++;
   endtask

   function automatic void check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %b, actual %b", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Response side: check each transaction against the oldest line bit due, then
   // draw how long to stall before the next one.
   initial begin
      int           hold;
      line_bit_type want;
      hold = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (bits_due.size() == 0) begin
               $display("%0t ns: line bit with none due, expected nothing, %s=%b tone=%b last=%b",
                        $time, "actual raw", rsp_raw_bit, rsp_line_tone, rsp_last_bit);
               mismatches++;
            end else begin
               want = bits_due.pop_front();
               check_field("raw_bit", want.raw, rsp_raw_bit);
               check_field("line_tone", want.tone, rsp_line_tone);
               check_field("last_bit", want.last, rsp_last_bit);
            end
            hold = quiet ? 0 : $urandom_range(0, 15);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus: directed table first, then random frames.
   initial begin
      stim_row_type directed [DIRECTED_ROWS];
      int           kind;
      int           len;
      logic [7:0]   dval;

      // Typed rows: a flag from mark gives tones 0000_0001 (read from bit 0 up);
      // eight zeros from mark alternate 0,1,0,1...; FCS straight after start is
      // sixteen zeros; 0xFF after a flag gets a zero stuffed after its fifth one.
      directed = '{
         '{ax25f_pkg::MODE_START, 8'hA5, 1'b1, 0,  20'h00000, 20'h00000},
         '{ax25f_pkg::MODE_FLAG,  8'hFF, 1'b1, 8,  20'h0007E, 20'h00080},
         '{ax25f_pkg::MODE_DATA,  8'h00, 1'b1, 8,  20'h00000, 20'h000AA},
         '{ax25f_pkg::MODE_FCS,   8'h00, 1'b0, 0,  20'h00000, 20'h00000},
         '{ax25f_pkg::MODE_START, 8'h00, 1'b1, 0,  20'h00000, 20'h00000},
         '{ax25f_pkg::MODE_FCS,   8'h5A, 1'b1, 16, 20'h00000, 20'h0AAAA},
         '{ax25f_pkg::MODE_START, 8'h3C, 1'b1, 0,  20'h00000, 20'h00000},
         '{ax25f_pkg::MODE_FLAG,  8'h00, 1'b1, 8,  20'h0007E, 20'h00080},
         '{ax25f_pkg::MODE_DATA,  8'hFF, 1'b1, 9,  20'h001DF, 20'h0001F},
         '{ax25f_pkg::MODE_DATA,  8'hFF, 1'b0, 0,  20'h00000, 20'h00000},
         '{ax25f_pkg::MODE_DATA,  8'hFF, 1'b0, 0,  20'h00000, 20'h00000},
         '{ax25f_pkg::MODE_FCS,   8'hFF, 1'b0, 0,  20'h00000, 20'h00000},
         '{ax25f_pkg::MODE_FCS,   8'h00, 1'b0, 0,  20'h00000, 20'h00000},
         '{ax25f_pkg::MODE_FLAG,  8'h81, 1'b0, 0,  20'h00000, 20'h00000},
         '{ax25f_pkg::MODE_START, 8'h00, 1'b1, 0,  20'h00000, 20'h00000},
         '{ax25f_pkg::MODE_DATA,  8'h7E, 1'b0, 0,  20'h00000, 20'h00000},
         '{ax25f_pkg::MODE_DATA,  8'h80, 1'b0, 0,  20'h00000, 20'h00000},
         '{ax25f_pkg::MODE_DATA,  8'h01, 1'b0, 0,  20'h00000, 20'h00000},
         '{ax25f_pkg::MODE_DATA,  8'h55, 1'b0, 0,  20'h00000, 20'h00000},
         '{ax25f_pkg::MODE_DATA,  8'hAA, 1'b0, 0,  20'h00000, 20'h00000},
         '{ax25f_pkg::MODE_DATA,  8'h3F, 1'b0, 0,  20'h00000, 20'h00000},
         '{ax25f_pkg::MODE_DATA,  8'hFC, 1'b0, 0,  20'h00000, 20'h00000},
         '{ax25f_pkg::MODE_FCS,   8'h00, 1'b0, 0,  20'h00000, 20'h00000},
         '{ax25f_pkg::MODE_FLAG,  8'h00, 1'b0, 0,  20'h00000, 20'h00000}
      };

      frame_line_bits(ax25f_pkg::MODE_START, 8'h00);
      wait (reset == 1'b0);
      @(posedge clock);

      foreach (directed[i]) send_item(directed[i]);

      // Mostly well-formed frames with random bodies, leaning towards dense ones
      // so that stuffing is hit often; some frames lack a start or an FCS, some
      // repeat the FCS, and the rest is noise in any mode.
      while (random_sent < RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 4) == 0);
         kind  = $urandom_range(0, 9);
         if (kind == 0) begin
            repeat ($urandom_range(1, 4))
               send_plain(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end else begin
            if (kind != 1) send_plain(ax25f_pkg::MODE_START, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 2))
               send_plain(ax25f_pkg::MODE_FLAG, 8'($urandom_range(0, 255)));
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(0, 3))
                  0:       dval = 8'hFF;
                  1:       dval = 8'($urandom | $urandom);
                  default: dval = 8'($urandom_range(0, 255));
               endcase
               send_plain(ax25f_pkg::MODE_DATA, dval);
            end
            if (kind != 2) send_plain(ax25f_pkg::MODE_FCS, 8'($urandom_range(0, 255)));
            if (kind == 3) send_plain(ax25f_pkg::MODE_FCS, 8'($urandom_range(0, 255)));
            send_plain(ax25f_pkg::MODE_FLAG, 8'($urandom_range(0, 255)));
         end
      end
      req_valid <= 1'b0;
      quiet = 1'b0;

      // Drain everything due, then give stray bits a chance to show up.
      while (bits_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Stop a hung run.
   initial begin
      #(WATCHDOG_NS);
      $display("Test completed with failures");
      $finish;
   end

endmodule

[ax25_hdlc_nrzi_framer.f]
+incdir+hdl
hdl/ax25f_pkg.sv
hdl/ax25f_front.sv
hdl/ax25f_queue.sv
hdl/ax25f_back.sv
hdl/ax25_hdlc_nrzi_framer.sv
dv/tb_ax25_hdlc_nrzi_framer.sv
